[sv/ptyp_pkg.sv]
// ----------------------------------------------------------------------------
// ptyp_pkg
// Widths, angle constants and shared helpers for the yaw/pitch pipeline.
// ----------------------------------------------------------------------------
package ptyp_pkg;

  localparam int IN_W     = 24;   // coordinate width, Q7.16
  localparam int GUARD_SH = 6;    // coordinates are scaled by 64 before the CORDIC
  localparam int CW       = 33;   // CORDIC x/y datapath width, signed
  localparam int AW       = 28;   // angle accumulator width, signed Q.24
  localparam int SQ_W     = 60;   // radicand width, (64x)^2 + (64y)^2
  localparam int ROOT_W   = SQ_W / 2;
  localparam int REM_W    = ROOT_W + 3;
  localparam int YAW_W    = 19;
  localparam int PITCH_W  = 18;
  localparam int TABLE_LEN = 24;

  localparam logic signed [AW-1:0] HALF_PI_Q24 = 28'sd26353589;
  localparam logic signed [AW-1:0] YAW_LIMIT   = 28'sd205887;
  localparam logic signed [AW-1:0] PITCH_LIMIT = 28'sd102944;
  localparam logic signed [AW-1:0] ROUND_HALF  = 28'sd128;

  // round(atan(2^-i) * 2^24)
  localparam logic signed [AW-1:0] ATAN_Q24 [TABLE_LEN] = '{
    28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
    28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069,
    28'sd65536,    28'sd32768,   28'sd16384,   28'sd8192,
    28'sd4096,     28'sd2048,    28'sd1024,    28'sd512,
    28'sd256,      28'sd128,     28'sd64,      28'sd32,
    28'sd16,       28'sd8,       28'sd4,       28'sd2
  };

  // Q.24 to Q.16 with round half up, then clamp to +-limit.
  function automatic logic signed [AW-1:0] round_clamp(
    input logic signed [AW-1:0] a,
    input logic signed [AW-1:0] limit
  );
    logic signed [AW-1:0] r;
    r = (a + ROUND_HALF) >>> 8;
    if (r > limit) begin
      r = limit;
    end else if (r < -limit) begin
      r = -limit;
    end
    return r;
  endfunction

endpackage

[sv/point_to_yaw_pitch_top.sv]
// ----------------------------------------------------------------------------
// point_to_yaw_pitch_top
// Fully pipelined conversion of a 3D point to yaw = atan2(y,x) and
// pitch = -atan2(z, hypot(x,y)) using a square root and two vectoring CORDICs.
// ----------------------------------------------------------------------------
// The block accepts one point request per clock while the output is not
// stalled and returns one result per point, in order. The pipeline holds one
// input register, one squaring stage, one sum stage, 30 stages of the
// bit-per-stage square root for the horizontal distance, one stage per CORDIC
// micro-rotation (yaw and pitch rotate side by side) and one rounding
// stage. A stall at the output freezes the whole pipeline; nothing is lost.

module point_to_yaw_pitch_top #(
  parameter int ITERATIONS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // target_x[23:0], target_y[47:24], target_z[71:48]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // yaw[18:0], pitch[36:19], zero fill [39:37]
);
  import ptyp_pkg::*;

  localparam int NIT = (ITERATIONS > TABLE_LEN) ? TABLE_LEN : ITERATIONS;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en && !rst;

  // Stage A: input register.
  logic                   av;
  logic signed [IN_W-1:0] ax, ay, az;

  always_ff @(posedge clk) begin
    if (rst) begin
      av <= 1'b0;
    end else if (en) begin
      av <= s_tvalid;
    end
    if (en) begin
      ax <= $signed(s_tdata[IN_W-1:0]);
      ay <= $signed(s_tdata[2*IN_W-1:IN_W]);
      az <= $signed(s_tdata[3*IN_W-1:2*IN_W]);
    end
  end

  // Stage B: squares, yaw quadrant fold, scaled z.
  logic signed [2*IN_W-1:0] xprod, yprod;
  logic signed [CW-1:0]     ax6, ay6, az6;
  logic signed [CW-1:0]     fx, fy;
  logic signed [AW-1:0]     fa;

  assign xprod = (2*IN_W)'(ax) * (2*IN_W)'(ax);
  assign yprod = (2*IN_W)'(ay) * (2*IN_W)'(ay);
  assign ax6   = {{(CW-IN_W-GUARD_SH){ax[IN_W-1]}}, ax, {GUARD_SH{1'b0}}};
  assign ay6   = {{(CW-IN_W-GUARD_SH){ay[IN_W-1]}}, ay, {GUARD_SH{1'b0}}};
  assign az6   = {{(CW-IN_W-GUARD_SH){az[IN_W-1]}}, az, {GUARD_SH{1'b0}}};

  // A vector in the left half plane is turned by a quarter turn first.
  always_comb begin
    priority if (ax[IN_W-1] && !ay[IN_W-1]) begin
      fx = ay6;
      fy = -ax6;
      fa = HALF_PI_Q24;
    end else if (ax[IN_W-1]) begin
      fx = -ay6;
      fy = ax6;
      fa = -HALF_PI_Q24;
    end else begin
      fx = ax6;
      fy = ay6;
      fa = '0;
    end
  end

  logic                   bv, b_yzero, b_pzero;
  logic [2*IN_W-2:0]      xsq, ysq;
  logic signed [CW-1:0]   bx, by, bz;
  logic signed [AW-1:0]   ba;

  always_ff @(posedge clk) begin
    if (rst) begin
      bv <= 1'b0;
    end else if (en) begin
      bv <= av;
    end
    if (en) begin
      xsq     <= xprod[2*IN_W-2:0];
      ysq     <= yprod[2*IN_W-2:0];
      bx      <= fx;
      by      <= fy;
      ba      <= fa;
      bz      <= az6;
      b_yzero <= (ax == '0) && (ay == '0);
      b_pzero <= (ax == '0) && (ay == '0) && (az == '0);
    end
  end

  // Stage C and the square root chain. Entry 0 holds the radicand.
  logic                   qv    [0:ROOT_W];
  logic [SQ_W-1:0]        qn    [0:ROOT_W];
  logic [REM_W-1:0]       qrem  [0:ROOT_W];
  logic [ROOT_W-1:0]      qroot [0:ROOT_W];
  logic signed [CW-1:0]   qx    [0:ROOT_W];
  logic signed [CW-1:0]   qy    [0:ROOT_W];
  logic signed [CW-1:0]   qz    [0:ROOT_W];
  logic signed [AW-1:0]   qa    [0:ROOT_W];
  logic                   qyz   [0:ROOT_W];
  logic                   qpz   [0:ROOT_W];

  logic [2*IN_W-1:0] sqsum;
  assign sqsum = {1'b0, xsq} + {1'b0, ysq};

  always_ff @(posedge clk) begin
    if (rst) begin
      qv[0] <= 1'b0;
    end else if (en) begin
      qv[0] <= bv;
    end
    if (en) begin
      qn[0]    <= {sqsum, {(2*GUARD_SH){1'b0}}};
      qrem[0]  <= '0;
      qroot[0] <= '0;
      qx[0]    <= bx;
      qy[0]    <= by;
      qz[0]    <= bz;
      qa[0]    <= ba;
      qyz[0]   <= b_yzero;
      qpz[0]   <= b_pzero;
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic [REM_W-1:0] rem_sh, trial;
    logic             fits;

    assign rem_sh = {qrem[k][REM_W-3:0], qn[k][SQ_W-1:SQ_W-2]};
    assign trial  = {1'b0, qroot[k], 2'b01};
    assign fits   = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        qv[k+1] <= 1'b0;
      end else if (en) begin
        qv[k+1] <= qv[k];
      end
      if (en) begin
        qn[k+1]    <= {qn[k][SQ_W-3:0], 2'b00};
        qrem[k+1]  <= fits ? (rem_sh - trial) : rem_sh;
        qroot[k+1] <= {qroot[k][ROOT_W-2:0], fits};
        qx[k+1]    <= qx[k];
        qy[k+1]    <= qy[k];
        qz[k+1]    <= qz[k];
        qa[k+1]    <= qa[k];
        qyz[k+1]   <= qyz[k];
        qpz[k+1]   <= qpz[k];
      end
    end
  end

  // CORDIC chain: yaw (y* signals) and pitch (p* signals) side by side.
  logic                 cv  [0:NIT];
  logic signed [CW-1:0] yx  [0:NIT];
  logic signed [CW-1:0] yy  [0:NIT];
  logic signed [AW-1:0] ya  [0:NIT];
  logic signed [CW-1:0] px  [0:NIT];
  logic signed [CW-1:0] py  [0:NIT];
  logic signed [AW-1:0] pa  [0:NIT];
  logic                 cyz [0:NIT];
  logic                 cpz [0:NIT];

  assign cv[0]  = qv[ROOT_W];
  assign yx[0]  = qx[ROOT_W];
  assign yy[0]  = qy[ROOT_W];
  assign ya[0]  = qa[ROOT_W];
  assign px[0]  = {{(CW-ROOT_W){1'b0}}, qroot[ROOT_W]};
  assign py[0]  = qz[ROOT_W];
  assign pa[0]  = '0;
  assign cyz[0] = qyz[ROOT_W];
  assign cpz[0] = qpz[ROOT_W];

  for (genvar i = 0; i < NIT; i++) begin : g_cordic
    logic signed [CW-1:0] ydx, ydy, pdx, pdy;

    assign ydx = yy[i] >>> i;
    assign ydy = yx[i] >>> i;
    assign pdx = py[i] >>> i;
    assign pdy = px[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else if (en) begin
        cv[i+1] <= cv[i];
      end
      if (en) begin
        if (!yy[i][CW-1]) begin
          yx[i+1] <= yx[i] + ydx;
          yy[i+1] <= yy[i] - ydy;
          ya[i+1] <= ya[i] + ATAN_Q24[i];
        end else begin
          yx[i+1] <= yx[i] - ydx;
          yy[i+1] <= yy[i] + ydy;
          ya[i+1] <= ya[i] - ATAN_Q24[i];
        end
        if (!py[i][CW-1]) begin
          px[i+1] <= px[i] + pdx;
          py[i+1] <= py[i] - pdy;
          pa[i+1] <= pa[i] + ATAN_Q24[i];
        end else begin
          px[i+1] <= px[i] - pdx;
          py[i+1] <= py[i] + pdy;
          pa[i+1] <= pa[i] - ATAN_Q24[i];
        end
        cyz[i+1] <= cyz[i];
        cpz[i+1] <= cpz[i];
      end
    end
  end

  // Output stage: round to Q.16 and clamp, or zero for a degenerate vector.
  logic signed [AW-1:0]      yaw_full, pitch_full;
  logic signed [YAW_W-1:0]   yaw;
  logic signed [PITCH_W-1:0] pitch;

  assign yaw_full   = round_clamp(ya[NIT], YAW_LIMIT);
  assign pitch_full = round_clamp(-pa[NIT], PITCH_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= cv[NIT];
    end
    if (en) begin
      yaw   <= cyz[NIT] ? '0 : yaw_full[YAW_W-1:0];
      pitch <= cpz[NIT] ? '0 : pitch_full[PITCH_W-1:0];
    end
  end

  assign m_tdata = {{(40-YAW_W-PITCH_W){1'b0}}, pitch, yaw};

  // The square root remainder never exceeds twice the root.
  a_root_rem: assert property (@(posedge clk) disable iff (rst)
    qv[ROOT_W] |-> (qrem[ROOT_W] <= {2'b00, qroot[ROOT_W], 1'b0}))
    else $error("square root remainder out of bound");

  // After the quadrant fold the yaw vector starts in the right half plane.
  a_fold: assert property (@(posedge clk) disable iff (rst)
    cv[0] |-> !yx[0][CW-1])
    else $error("yaw vector not folded into right half plane");

  // An accepted request enters the first stage.
  a_enter: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> av)
    else $error("accepted request did not enter the pipeline");

  // Delivered angles stay inside their limits.
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (yaw <= 19'sd205887) && (yaw >= -19'sd205887) &&
                 (pitch <= 18'sd102944) && (pitch >= -18'sd102944))
    else $error("output angle out of range");

endmodule
